@@ src/lrb_pkg.sv @@
// ----------------------------------------------------------------------------
// lrb_pkg
// Shared types and constants for the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrb_pkg;

    localparam int CB = 6;       // coordinate bits
    localparam int PW = CB + 3;  // decision value width, signed

    typedef logic [CB-1:0]        coord_t;
    typedef logic signed [PW-1:0] dec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PREP,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic prep;
        logic walk;
        logic last;
    } ctrl_t;

endpackage

`default_nettype wire

@@ src/lrb_step.sv @@
// ----------------------------------------------------------------------------
// lrb_step
// Shared step unit: advances the pixel position and the decision value.
// ----------------------------------------------------------------------------
`default_nettype none

module lrb_step (
    input  lrb_pkg::coord_t x,
    input  lrb_pkg::coord_t y,
    input  lrb_pkg::dec_t   p,
    input  lrb_pkg::dec_t   inc_minor,
    input  lrb_pkg::dec_t   inc_both,
    input  logic            x_major,
    input  logic            sy_neg,
    output lrb_pkg::coord_t x_step,
    output lrb_pkg::coord_t y_step,
    output lrb_pkg::dec_t   p_step
);
    import lrb_pkg::*;

    coord_t x_inc;
    coord_t y_inc;
    logic   minor_only;

    assign x_inc      = x + coord_t'(1);
    assign y_inc      = sy_neg ? (y - coord_t'(1)) : (y + coord_t'(1));
    assign minor_only = p[PW-1];

    always_comb
    begin
        if (minor_only)
        begin
            x_step = x_major ? x_inc : x;
            y_step = x_major ? y : y_inc;
            p_step = p + inc_minor;
        end
        else
        begin
            x_step = x_inc;
            y_step = y_inc;
            p_step = p + inc_both;
        end
    end

endmodule

`default_nettype wire

@@ src/lrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrb_ctrl
// Sequencer: setup phases, then one step per pixel with a down counter.
// ----------------------------------------------------------------------------
`default_nettype none

module lrb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  lrb_pkg::coord_t major,
    output logic            busy,
    output lrb_pkg::ctrl_t  ctrl
);
    import lrb_pkg::*;

    state_t state_reg;
    state_t state_next;
    coord_t cnt_reg;
    coord_t cnt_next;
    logic   last;

    assign last = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_PREP;
            ST_PREP:  state_next = ST_WALK;
            ST_WALK:  if (last) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == ST_PREP)
            cnt_next = major;
        else if (state_reg == ST_WALK && !last)
            cnt_next = cnt_reg - coord_t'(1);
    end

    always_comb
    begin
        busy       = 1'b1;
        ctrl.load  = 1'b0;
        ctrl.setup = 1'b0;
        ctrl.prep  = 1'b0;
        ctrl.walk  = 1'b0;
        ctrl.last  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy      = 1'b0;
                ctrl.load = start;
            end
            ST_SETUP: ctrl.setup = 1'b1;
            ST_PREP:  ctrl.prep  = 1'b1;
            ST_WALK:
            begin
                ctrl.walk = 1'b1;
                ctrl.last = last;
            end
            default:  busy = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ src/line_rasterizer_bresenham.sv @@
// ----------------------------------------------------------------------------
// line_rasterizer_bresenham
// Bresenham line rasterizer for a 64x64 tile, all octants.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low;
//   x_start/y_start/x_end/y_end are sampled there. busy stays high until the
//   last pixel has been emitted.
//   Each pixel appears on pixel_x/pixel_y for one cycle with strobe high;
//   last_pixel marks the final pixel. The receiver has no backpressure.
// Sequence:
//   The endpoints are put in order when they are loaded at acceptance. The
//   SETUP state computes the deltas, then PREP the decision terms; then one
//   pixel per cycle comes from the shared step unit, for a line of
//   n = max(|dx|,|dy|) + 1 pixels. busy then drops, and the next start is
//   taken once the last pixel has been emitted.
// Reset:
//   rst_n clears the sequencer; the block comes up idle with no strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer_bresenham (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  lrb_pkg::coord_t x_start,
    input  lrb_pkg::coord_t y_start,
    input  lrb_pkg::coord_t x_end,
    input  lrb_pkg::coord_t y_end,
    output logic            strobe,
    output lrb_pkg::coord_t pixel_x,
    output lrb_pkg::coord_t pixel_y,
    output logic            last_pixel
);
    import lrb_pkg::*;

    ctrl_t  ctrl;
    coord_t x_reg;
    coord_t y_reg;
    coord_t xe_reg;
    coord_t ye_reg;
    coord_t dx_reg;
    coord_t ady_reg;
    logic   sy_neg_reg;
    logic   x_major_reg;
    coord_t major;
    coord_t minor;
    dec_t   p_reg;
    dec_t   inc_minor_reg;
    dec_t   inc_both_reg;
    coord_t x_step;
    coord_t y_step;
    dec_t   p_step;
    logic   swap;
    logic   x_major;

    assign swap = !((x_start < x_end) || ((x_start == x_end) && (y_start <= y_end)));

    assign x_major = (dx_reg > ady_reg);
    assign major   = x_major ? dx_reg  : ady_reg;
    assign minor   = x_major ? ady_reg : dx_reg;

    lrb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .major (major),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    lrb_step u_step (
        .x         (x_reg),
        .y         (y_reg),
        .p         (p_reg),
        .inc_minor (inc_minor_reg),
        .inc_both  (inc_both_reg),
        .x_major   (x_major_reg),
        .sy_neg    (sy_neg_reg),
        .x_step    (x_step),
        .y_step    (y_step),
        .p_step    (p_step)
    );

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg  <= swap ? x_end   : x_start;
            y_reg  <= swap ? y_end   : y_start;
            xe_reg <= swap ? x_start : x_end;
            ye_reg <= swap ? y_start : y_end;
        end
        else if (ctrl.walk)
        begin
            x_reg <= x_step;
            y_reg <= y_step;
        end

        if (ctrl.setup)
        begin
            dx_reg     <= xe_reg - x_reg;
            sy_neg_reg <= (ye_reg < y_reg);
            ady_reg    <= (ye_reg < y_reg) ? (y_reg - ye_reg) : (ye_reg - y_reg);
        end

        if (ctrl.prep)
        begin
            x_major_reg   <= x_major;
            inc_minor_reg <= dec_t'({minor, 1'b0});
            inc_both_reg  <= dec_t'({minor, 1'b0}) - dec_t'({major, 1'b0});
            p_reg         <= dec_t'({minor, 1'b0}) - dec_t'(major);
        end
        else if (ctrl.walk)
        begin
            p_reg <= p_step;
        end
    end

    assign strobe     = ctrl.walk;
    assign pixel_x    = x_reg;
    assign pixel_y    = y_reg;
    assign last_pixel = ctrl.last;

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("strobe while idle");

    a_run_on: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_pixel) |=> strobe)
        else $error("pixel run broken before last pixel");

    a_setup_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !strobe))
        else $error("no setup cycle after accept");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_pixel) |=> !busy)
        else $error("still busy after last pixel");

endmodule

`default_nettype wire
